// File: sv/kf2d_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the 2D tracker.
`default_nettype none
package kf2d_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 31;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t ONE  = word_t'(1) <<< FRAC_W;

    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_UPDATE  = 2'd1;
    localparam logic [1:0] MODE_INIT    = 2'd2;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_INITDONE = 2'd2;
    localparam logic [1:0] ST_SINGULAR = 2'd3;

    localparam logic [1:0] REG_POS_NOISE = 2'd0;
    localparam logic [1:0] REG_VEL_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic [1:0] REG_DET_THR   = 2'd3;

    function automatic word_t f_sat(input logic signed [WORD_W+1:0] v);
        if (v > $signed({2'b00, WMAX}))
            return WMAX;
        if (v < $signed({2'b11, WMIN}))
            return WMIN;
        return v[WORD_W-1:0];
    endfunction

    function automatic word_t f_addsub(input word_t a, input word_t b, input logic sub);
        logic signed [WORD_W+1:0] s;
        if (sub)
            s = {{2{a[WORD_W-1]}}, a} - {{2{b[WORD_W-1]}}, b};
        else
            s = {{2{a[WORD_W-1]}}, a} + {{2{b[WORD_W-1]}}, b};
        return f_sat(s);
    endfunction

    function automatic word_t f_neg(input word_t a);
        if (a == WMIN)
            return WMAX;
        return -a;
    endfunction

    function automatic word_t f_mul(input word_t a, input word_t b);
        logic                  neg;
        logic [WORD_W-1:0]     ua;
        logic [WORD_W-1:0]     ub;
        logic [2*WORD_W-1:0]   p;
        logic [2*WORD_W-FRAC_W-1:0] r;
        neg = a[WORD_W-1] ^ b[WORD_W-1];
        ua  = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
        ub  = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
        p   = (2*WORD_W)'(ua) * (2*WORD_W)'(ub);
        p   = p + ((2*WORD_W)'(1) << (FRAC_W - 1));
        r   = p[2*WORD_W-1:FRAC_W];
        if (r > (2*WORD_W-FRAC_W)'(WMAX))
            return neg ? WMIN : WMAX;
        return neg ? -word_t'(r[WORD_W-1:0]) : word_t'(r[WORD_W-1:0]);
    endfunction

    function automatic word_t f_trans(input logic [1:0] r, input logic [1:0] c,
                                      input word_t dt);
        if (r == c)
            return ONE;
        if ((r == 2'd0 && c == 2'd2) || (r == 2'd1 && c == 2'd3))
            return dt;
        return '0;
    endfunction

endpackage
`default_nettype wire

// File: sv/kalman_tracker_2d_const_velocity_unit.sv
// Constant-velocity 2D tracker: state store, sequencer, shared multiplier, adder and divider.
//
// One request is taken at a time; s_tready is high only while the sequencer is idle.
// Initialize, ignored predict and mode three go straight to the output stage. Predict and
// update run on one shared multiplier and one shared saturating adder (a singular update
// stops after the determinant check): each 4x4 matrix product is 64 multiply and
// accumulate steps, a predict runs two such products and an update one, and the
// reciprocal of the innovation determinant comes from a restoring divider.
// A finished result waits in the output register until m_tready takes it.
`default_nettype none
module kalman_tracker_2d_const_velocity_unit import kf2d_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [95:0]  s_tdata,   // time_step[30:0], meas_x[62:31], meas_y[94:63]
    input  wire logic [1:0]   s_tuser,   // mode[1:0]
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [127:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y, 32 bits each
    output      logic [1:0]   m_tuser,   // status[1:0]
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_Y0 = 5'd1,  S_Y1 = 5'd2,  S_S0 = 5'd3;
    localparam logic [4:0] S_S3   = 5'd4,  S_M1 = 5'd5,  S_M2 = 5'd6,  S_DET = 5'd7;
    localparam logic [4:0] S_CHK  = 5'd8,  S_DIV = 5'd9, S_INV = 5'd10, S_SI0 = 5'd11;
    localparam logic [4:0] S_SI1  = 5'd12, S_SI2 = 5'd13, S_SI3 = 5'd14, S_KA = 5'd15;
    localparam logic [4:0] S_KB   = 5'd16, S_KC = 5'd17, S_KD = 5'd18, S_KE = 5'd19;
    localparam logic [4:0] S_KF   = 5'd20, S_VA = 5'd21, S_VB = 5'd22, S_VC = 5'd23;
    localparam logic [4:0] S_VD   = 5'd24, S_PM = 5'd25, S_PA = 5'd26, S_MMUL = 5'd27;
    localparam logic [4:0] S_MADD = 5'd28, S_PQ = 5'd29, S_COPY = 5'd30, S_OUT = 5'd31;

    localparam logic [1:0] PASS_FP   = 2'd0;
    localparam logic [1:0] PASS_FPFT = 2'd1;
    localparam logic [1:0] PASS_UPD  = 2'd2;

    logic [4:0]        state_reg, state_next;
    logic [1:0]        idx_reg, i_reg, j_reg, k_reg, pass_reg;
    logic              init_reg;
    word_t             vec_reg [4];
    word_t             cov_reg [16];
    word_t             tmp_reg [16];
    word_t             kg_reg  [8];
    word_t             si_reg  [4];
    word_t             dt_reg, mx_reg, my_reg;
    word_t             y0_reg, y1_reg, s0_reg, s3_reg, t1_reg, t2_reg, det_reg;
    word_t             inv_reg, acc_reg;
    logic [31:0]       rem_reg;
    logic [32:0]       quo_reg;
    logic [5:0]        cnt_reg;
    logic [1:0]        status_reg;
    logic              m_tvalid_reg;
    logic [127:0]      m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic [CFG_W-1:0]  cfg_reg [4];

    word_t             mul_a, mul_b, mul_y, add_a, add_b, add_y;
    logic              add_sub;
    word_t             mm_a, mm_b, kh, rn, noise;
    logic [31:0]       ad;
    logic [32:0]       trial;
    logic              in_acc, out_load, cfg_wr;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign cfg_wr   = psel && penable && pwrite;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign prdata   = {1'b0, cfg_reg[paddr[3:2]]};

    assign rn    = word_t'({1'b0, cfg_reg[REG_MEAS_NOISE]});
    assign noise = idx_reg[1] ? word_t'({1'b0, cfg_reg[REG_VEL_NOISE]})
                              : word_t'({1'b0, cfg_reg[REG_POS_NOISE]});
    assign ad    = det_reg[WORD_W-1] ? 32'(-det_reg) : 32'(det_reg);
    assign trial = {rem_reg, quo_reg[32]};

    always_comb begin
        kh = '0;
        if (k_reg == 2'd0)
            kh = kg_reg[{i_reg, 1'b0}];
        else if (k_reg == 2'd1)
            kh = kg_reg[{i_reg, 1'b1}];
        unique case (pass_reg)
            PASS_FP: begin
                mm_a = f_trans(i_reg, k_reg, dt_reg);
                mm_b = cov_reg[{k_reg, j_reg}];
            end
            PASS_FPFT: begin
                mm_a = tmp_reg[{i_reg, k_reg}];
                mm_b = f_trans(j_reg, k_reg, dt_reg);
            end
            default: begin
                mm_a = f_addsub((i_reg == k_reg) ? ONE : '0, kh, 1'b1);
                mm_b = cov_reg[{k_reg, j_reg}];
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M1:    begin mul_a = s0_reg;                      mul_b = s3_reg;  end
            S_M2:    begin mul_a = cov_reg[1];                  mul_b = cov_reg[4]; end
            S_SI0:   begin mul_a = s3_reg;                      mul_b = inv_reg; end
            S_SI1:   begin mul_a = f_neg(cov_reg[1]);           mul_b = inv_reg; end
            S_SI2:   begin mul_a = f_neg(cov_reg[4]);           mul_b = inv_reg; end
            S_SI3:   begin mul_a = s0_reg;                      mul_b = inv_reg; end
            S_KA:    begin mul_a = cov_reg[{idx_reg, 2'd0}];    mul_b = si_reg[0]; end
            S_KB:    begin mul_a = cov_reg[{idx_reg, 2'd1}];    mul_b = si_reg[2]; end
            S_KD:    begin mul_a = cov_reg[{idx_reg, 2'd0}];    mul_b = si_reg[1]; end
            S_KE:    begin mul_a = cov_reg[{idx_reg, 2'd1}];    mul_b = si_reg[3]; end
            S_VA:    begin mul_a = kg_reg[{idx_reg, 1'b0}];     mul_b = y0_reg;  end
            S_VB:    begin mul_a = kg_reg[{idx_reg, 1'b1}];     mul_b = y1_reg;  end
            S_PM:    begin mul_a = dt_reg;                      mul_b = vec_reg[{1'b1, idx_reg[0]}]; end
            S_MMUL:  begin mul_a = mm_a;                        mul_b = mm_b;    end
            default: begin mul_a = '0;                          mul_b = '0;      end
        endcase
        mul_y = f_mul(mul_a, mul_b);
    end

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            S_Y0:    begin add_a = mx_reg;     add_b = vec_reg[0]; add_sub = 1'b1; end
            S_Y1:    begin add_a = my_reg;     add_b = vec_reg[1]; add_sub = 1'b1; end
            S_S0:    begin add_a = cov_reg[0]; add_b = rn;        end
            S_S3:    begin add_a = cov_reg[5]; add_b = rn;        end
            S_DET:   begin add_a = t1_reg;     add_b = t2_reg;    add_sub = 1'b1; end
            S_KC, S_KF, S_VC: begin add_a = t1_reg; add_b = t2_reg; end
            S_VD:    begin add_a = vec_reg[idx_reg]; add_b = t1_reg; end
            S_PA:    begin add_a = vec_reg[{1'b0, idx_reg[0]}]; add_b = t1_reg; end
            S_MADD:  begin add_a = (k_reg == 2'd0) ? '0 : acc_reg; add_b = t1_reg; end
            S_PQ:    begin add_a = cov_reg[{idx_reg, idx_reg}]; add_b = noise; end
            default: begin add_a = '0;         add_b = '0;        end
        endcase
        add_y = f_addsub(add_a, add_b, add_sub);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == MODE_PREDICT && init_reg)
                        state_next = S_PM;
                    else if (s_tuser == MODE_UPDATE && init_reg)
                        state_next = S_Y0;
                    else
                        state_next = S_OUT;
                end
            end
            S_CHK:  state_next = (ad == '0 || ad < {1'b0, cfg_reg[REG_DET_THR]}) ? S_OUT : S_DIV;
            S_DIV:  state_next = (cnt_reg == 6'd32) ? S_INV : S_DIV;
            S_KF:   state_next = (idx_reg == 2'd3) ? S_VA : S_KA;
            S_VD:   state_next = (idx_reg == 2'd3) ? S_MMUL : S_VA;
            S_PA:   state_next = (idx_reg == 2'd1) ? S_MMUL : S_PM;
            S_MADD: begin
                if (i_reg == 2'd3 && j_reg == 2'd3 && k_reg == 2'd3) begin
                    unique case (pass_reg)
                        PASS_FP:   state_next = S_MMUL;
                        PASS_FPFT: state_next = S_PQ;
                        default:   state_next = S_COPY;
                    endcase
                end else begin
                    state_next = S_MMUL;
                end
            end
            S_PQ:   state_next = (idx_reg == 2'd3) ? S_OUT : S_PQ;
            S_COPY: state_next = S_OUT;
            S_OUT:  state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = state_reg + 5'd1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            init_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cfg_reg[REG_POS_NOISE]  <= CFG_W'(655);
            cfg_reg[REG_VEL_NOISE]  <= CFG_W'(6554);
            cfg_reg[REG_MEAS_NOISE] <= CFG_W'(65536);
            cfg_reg[REG_DET_THR]    <= CFG_W'(1);
            for (int n = 0; n < 4; n++)
                vec_reg[n] <= '0;
            for (int n = 0; n < 16; n++)
                cov_reg[n] <= (n % 5 == 0) ? ONE : '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr)
                cfg_reg[paddr[3:2]] <= pwdata[CFG_W-1:0];
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        dt_reg     <= word_t'({1'b0, s_tdata[30:0]});
                        mx_reg     <= s_tdata[62:31];
                        my_reg     <= s_tdata[94:63];
                        idx_reg    <= '0;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        k_reg      <= '0;
                        status_reg <= ST_IGNORED;
                        if (s_tuser == MODE_PREDICT)
                            pass_reg <= PASS_FP;
                        else
                            pass_reg <= PASS_UPD;
                        if (s_tuser == MODE_INIT || (s_tuser == MODE_UPDATE && !init_reg)) begin
                            vec_reg[0] <= s_tdata[62:31];
                            vec_reg[1] <= s_tdata[94:63];
                            vec_reg[2] <= '0;
                            vec_reg[3] <= '0;
                            for (int n = 0; n < 16; n++)
                                cov_reg[n] <= (n % 5 == 0) ? ONE : '0;
                            init_reg   <= 1'b1;
                            status_reg <= ST_INITDONE;
                        end
                    end
                end
                S_Y0:  y0_reg  <= add_y;
                S_Y1:  y1_reg  <= add_y;
                S_S0:  s0_reg  <= add_y;
                S_S3:  s3_reg  <= add_y;
                S_M1:  t1_reg  <= mul_y;
                S_M2:  t2_reg  <= mul_y;
                S_DET: det_reg <= add_y;
                S_CHK: begin
                    status_reg <= ST_SINGULAR;
                    rem_reg    <= '0;
                    quo_reg    <= {1'b1, 32'd0} + {2'b00, ad[31:1]};
                    cnt_reg    <= '0;
                end
                S_DIV: begin
                    if (trial >= {1'b0, ad}) begin
                        rem_reg <= 32'(trial - {1'b0, ad});
                        quo_reg <= {quo_reg[31:0], 1'b1};
                    end else begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[31:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_INV: begin
                    status_reg <= ST_APPLIED;
                    if (quo_reg > 33'(WMAX))
                        inv_reg <= det_reg[WORD_W-1] ? WMIN : WMAX;
                    else
                        inv_reg <= det_reg[WORD_W-1] ? -word_t'(quo_reg[31:0])
                                                     : word_t'(quo_reg[31:0]);
                end
                S_SI0: si_reg[0] <= mul_y;
                S_SI1: si_reg[1] <= mul_y;
                S_SI2: si_reg[2] <= mul_y;
                S_SI3: si_reg[3] <= mul_y;
                S_KA, S_KD, S_VA, S_PM, S_MMUL: t1_reg <= mul_y;
                S_KB, S_KE, S_VB: t2_reg <= mul_y;
                S_KC: kg_reg[{idx_reg, 1'b0}] <= add_y;
                S_KF: begin
                    kg_reg[{idx_reg, 1'b1}] <= add_y;
                    idx_reg <= idx_reg + 2'd1;
                end
                S_VC: t1_reg <= add_y;
                S_VD: begin
                    vec_reg[idx_reg] <= add_y;
                    idx_reg <= idx_reg + 2'd1;
                end
                S_PA: begin
                    vec_reg[{1'b0, idx_reg[0]}] <= add_y;
                    idx_reg <= (idx_reg == 2'd1) ? 2'd0 : idx_reg + 2'd1;
                end
                S_MADD: begin
                    acc_reg <= add_y;
                    if (k_reg == 2'd3) begin
                        if (pass_reg == PASS_FPFT)
                            cov_reg[{i_reg, j_reg}] <= add_y;
                        else
                            tmp_reg[{i_reg, j_reg}] <= add_y;
                        if (j_reg == 2'd3)
                            i_reg <= i_reg + 2'd1;
                        j_reg <= j_reg + 2'd1;
                        if (i_reg == 2'd3 && j_reg == 2'd3 && pass_reg == PASS_FP)
                            pass_reg <= PASS_FPFT;
                    end
                    k_reg <= k_reg + 2'd1;
                end
                S_PQ: begin
                    cov_reg[{idx_reg, idx_reg}] <= add_y;
                    idx_reg    <= idx_reg + 2'd1;
                    status_reg <= ST_APPLIED;
                end
                S_COPY: begin
                    for (int n = 0; n < 16; n++)
                        cov_reg[n] <= tmp_reg[n];
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tdata_reg <= {vec_reg[3], vec_reg[2], vec_reg[1], vec_reg[0]};
                        m_tuser_reg <= status_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sv/kf2d_checker.sv
// Port-level checks for the 2D tracker and their binding to the top level.
`default_nettype none
module kf2d_checker import kf2d_pkg::*; (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_init_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_INITDONE |-> m_tdata[127:64] == '0)
        else $error("velocity not cleared on initialize");

endmodule

bind kalman_tracker_2d_const_velocity_unit kf2d_checker u_kf2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the 2D constant-velocity tracker: random and directed requests.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import kf2d_pkg::*;

    typedef struct packed {
        logic [1:0]  mode;
        logic [30:0] dt;
        logic [31:0] mx;
        logic [31:0] my;
    } request_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [1:0]  status;
    } estimate_t;

    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] MODE_NOP = 2'd3;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire [127:0]  m_tdata;
    wire [1:0]    m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    wire [31:0]   prdata;
    wire          pready;

    kalman_tracker_2d_const_velocity_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Tracker model state
    word_t     trk_state [4];
    word_t     trk_cov [16];
    logic      trk_live;
    word_t     noise_pos, noise_vel, noise_meas, det_min;

    request_t  pending_reqs [$];
    estimate_t expected_estimates [$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    bit        idle_free = 1'b0;
    bit        stim_done = 1'b0;

    function automatic word_t sadd(word_t a, word_t b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        if (s > 34'sd2147483647) return WMAX;
        if (s < -34'sd2147483648) return WMIN;
        return s[31:0];
    endfunction

    function automatic word_t ssub(word_t a, word_t b);
        logic signed [33:0] s;
        s = 34'(a) - 34'(b);
        if (s > 34'sd2147483647) return WMAX;
        if (s < -34'sd2147483648) return WMIN;
        return s[31:0];
    endfunction

    function automatic word_t qmul(word_t a, word_t b);
        logic        neg;
        logic [63:0] ua, ub;
        logic [127:0] p;
        neg = a[31] ^ b[31];
        ua = a[31] ? 64'(-65'(a)) : 64'(a);
        ub = b[31] ? 64'(-65'(b)) : 64'(b);
        p = (128'(ua) * 128'(ub) + 128'(32768)) >> 16;
        if (p > 128'(2147483647)) return neg ? WMIN : WMAX;
        return neg ? -word_t'(p[31:0]) : word_t'(p[31:0]);
    endfunction

    function automatic void mat_product(input word_t a [16], input word_t b [16],
                                        output word_t c [16]);
        word_t s;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                s = '0;
                for (int k = 0; k < 4; k++) s = sadd(s, qmul(a[i*4+k], b[k*4+j]));
                c[i*4+j] = s;
            end
    endfunction

    function automatic void track_reset_cov();
        foreach (trk_cov[i]) trk_cov[i] = '0;
        trk_cov[0] = ONE; trk_cov[5] = ONE; trk_cov[10] = ONE; trk_cov[15] = ONE;
    endfunction

    function automatic void track_init(word_t mx, word_t my);
        trk_state[0] = mx; trk_state[1] = my; trk_state[2] = '0; trk_state[3] = '0;
        track_reset_cov();
        trk_live = 1'b1;
    endfunction

    function automatic void track_predict(word_t dt);
        word_t f [16], ft [16], fp [16], r [16];
        trk_state[0] = sadd(trk_state[0], qmul(dt, trk_state[2]));
        trk_state[1] = sadd(trk_state[1], qmul(dt, trk_state[3]));
        foreach (f[i]) f[i] = '0;
        f[0] = ONE; f[5] = ONE; f[10] = ONE; f[15] = ONE; f[2] = dt; f[7] = dt;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) ft[j*4+i] = f[i*4+j];
        mat_product(f, trk_cov, fp);
        mat_product(fp, ft, r);
        trk_cov = r;
        trk_cov[0] = sadd(trk_cov[0], noise_pos);
        trk_cov[5] = sadd(trk_cov[5], noise_pos);
        trk_cov[10] = sadd(trk_cov[10], noise_vel);
        trk_cov[15] = sadd(trk_cov[15], noise_vel);
    endfunction

    function automatic logic [1:0] track_update(word_t mx, word_t my);
        word_t y0, y1, s0, s1, s2, s3, det, inv, h0, h1;
        word_t si [4], kg [8], ikh [16], np [16];
        logic [32:0] ad;
        logic [63:0] q;
        y0 = ssub(mx, trk_state[0]);
        y1 = ssub(my, trk_state[1]);
        s0 = sadd(trk_cov[0], noise_meas); s1 = trk_cov[1];
        s2 = trk_cov[4]; s3 = sadd(trk_cov[5], noise_meas);
        det = ssub(qmul(s0, s3), qmul(s1, s2));
        ad = det[31] ? 33'(-34'(det)) : 33'(det);
        if (ad == '0 || ad < 33'(det_min)) return ST_SINGULAR;
        q = ((64'd1 << 32) + 64'(ad >> 1)) / 64'(ad);
        if (det[31]) inv = (q > 64'd2147483648) ? WMIN : -word_t'(q[31:0]);
        else inv = (q > 64'd2147483647) ? WMAX : word_t'(q[31:0]);
        si[0] = qmul(s3, inv);
        si[1] = qmul(ssub('0, s1), inv);
        si[2] = qmul(ssub('0, s2), inv);
        si[3] = qmul(s0, inv);
        for (int i = 0; i < 4; i++) begin
            h0 = trk_cov[i*4]; h1 = trk_cov[i*4+1];
            kg[i*2] = sadd(qmul(h0, si[0]), qmul(h1, si[2]));
            kg[i*2+1] = sadd(qmul(h0, si[1]), qmul(h1, si[3]));
        end
        for (int i = 0; i < 4; i++)
            trk_state[i] = sadd(trk_state[i],
                                sadd(qmul(kg[i*2], y0), qmul(kg[i*2+1], y1)));
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                ikh[i*4+j] = ssub((i == j) ? ONE : '0,
                                  (j == 0) ? kg[i*2] : ((j == 1) ? kg[i*2+1] : '0));
        mat_product(ikh, trk_cov, np);
        trk_cov = np;
        return ST_APPLIED;
    endfunction

    function automatic estimate_t track_step(request_t r);
        estimate_t e;
        logic [1:0] st;
        st = ST_IGNORED;
        case (r.mode)
            MODE_PREDICT: begin
                if (trk_live) begin
                    track_predict(word_t'({1'b0, r.dt}));
                    st = ST_APPLIED;
                end
            end
            MODE_UPDATE: begin
                if (!trk_live) begin
                    track_init(r.mx, r.my);
                    st = ST_INITDONE;
                end else begin
                    st = track_update(r.mx, r.my);
                end
            end
            MODE_INIT: begin
                track_init(r.mx, r.my);
                st = ST_INITDONE;
            end
            default: ;
        endcase
        e.px = trk_state[0]; e.py = trk_state[1];
        e.vx = trk_state[2]; e.vy = trk_state[3];
        e.status = st;
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && (idle_free || $urandom_range(99) >= 35)) begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    expected_estimates.push_back(track_step(r));
                    s_tdata <= {1'b0, r.my, r.mx, r.dt};
                    s_tuser <= r.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= idle_free || ($urandom_range(99) >= 35);
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                estimate_t e;
                e = expected_estimates.pop_front();
                if (m_tdata[31:0] !== e.px) report_mismatch("pos_x", m_tdata[31:0], e.px);
                if (m_tdata[63:32] !== e.py) report_mismatch("pos_y", m_tdata[63:32], e.py);
                if (m_tdata[95:64] !== e.vx) report_mismatch("vel_x", m_tdata[95:64], e.vx);
                if (m_tdata[127:96] !== e.vy)
                    report_mismatch("vel_y", m_tdata[127:96], e.vy);
                if (m_tuser !== e.status)
                    report_mismatch("status", 32'(m_tuser), 32'(e.status));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [30:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {1'b0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_POS_NOISE:  noise_pos = word_t'({1'b0, val});
            REG_VEL_NOISE:  noise_vel = word_t'({1'b0, val});
            REG_MEAS_NOISE: noise_meas = word_t'({1'b0, val});
            default:        det_min = word_t'({1'b0, val});
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_estimates.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
        endcase
    endfunction

    function automatic logic [30:0] rand_dt();
        case ($urandom_range(7))
            0: return 31'($urandom);
            1: return '0;
            default: return 31'($urandom_range(131072));
        endcase
    endfunction

    task automatic push_req(logic [1:0] m, logic [30:0] dt, logic [31:0] x, logic [31:0] y);
        request_t r;
        r.mode = m; r.dt = dt; r.mx = x; r.my = y;
        pending_reqs.push_back(r);
    endtask

    task automatic random_phase(input int n);
        int k;
        k = 0;
        while (k < n) begin
            if ($urandom_range(9) < 8) begin
                push_req(MODE_INIT, 31'($urandom), rand_pos(), rand_pos());
                repeat ($urandom_range(8, 2)) begin
                    push_req(MODE_PREDICT, rand_dt(), $urandom, $urandom);
                    push_req(MODE_UPDATE, 31'($urandom), rand_pos(), rand_pos());
                    k += 2;
                end
                k++;
            end else begin
                push_req(2'($urandom_range(3)), 31'($urandom), $urandom, $urandom);
                k++;
            end
        end
    endtask

    initial begin
        trk_live = 1'b0;
        foreach (trk_state[i]) trk_state[i] = '0;
        track_reset_cov();
        noise_pos = 655; noise_vel = 6554; noise_meas = 65536; det_min = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        push_req(MODE_PREDICT, 31'h7FFFFFFF, '0, '0);
        push_req(MODE_NOP, '0, 32'h7FFFFFFF, 32'h80000000);
        push_req(MODE_UPDATE, '0, 32'h00010000, 32'hFFFF0000);
        push_req(MODE_PREDICT, 31'h00010000, '0, '0);
        push_req(MODE_UPDATE, '0, 32'h00030000, 32'hFFFD0000);
        push_req(MODE_PREDICT, 31'h00008000, '0, '0);
        push_req(MODE_UPDATE, '0, 32'h7FFFFFFF, 32'h80000000);
        push_req(MODE_PREDICT, 31'h7FFFFFFF, '0, '0);
        push_req(MODE_UPDATE, '0, 32'h80000000, 32'h7FFFFFFF);
        push_req(MODE_INIT, 31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        push_req(MODE_PREDICT, '0, '0, '0);
        push_req(MODE_NOP, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_req(MODE_UPDATE, '0, 32'hFFFFFFFF, '0);
        drain();

        // Singular: huge threshold skips every update
        reg_write(REG_DET_THR, 31'h7FFFFFFF);
        push_req(MODE_INIT, '0, 32'h00050000, 32'h00050000);
        push_req(MODE_UPDATE, '0, 32'h00060000, 32'h00040000);
        push_req(MODE_PREDICT, 31'h00010000, '0, '0);
        push_req(MODE_UPDATE, '0, 32'h00070000, 32'h00030000);
        drain();

        // Zero noise, zero threshold: determinant may reach zero
        reg_write(REG_DET_THR, '0);
        reg_write(REG_MEAS_NOISE, '0);
        reg_write(REG_POS_NOISE, '0);
        reg_write(REG_VEL_NOISE, '0);
        push_req(MODE_INIT, '0, 32'h00010000, 32'h00010000);
        push_req(MODE_UPDATE, '0, 32'h00020000, 32'h00020000);
        push_req(MODE_UPDATE, '0, 32'h00020000, 32'h00020000);
        push_req(MODE_PREDICT, 31'h00010000, '0, '0);
        drain();

        idle_free = 1'b1;
        reg_write(REG_POS_NOISE, 31'(655));
        reg_write(REG_VEL_NOISE, 31'(6554));
        reg_write(REG_MEAS_NOISE, 31'(65536));
        reg_write(REG_DET_THR, 31'(1));
        random_phase(250);
        drain();
        idle_free = 1'b0;
        random_phase(450);
        drain();

        reg_write(REG_POS_NOISE, 31'h7FFFFFFF);
        reg_write(REG_VEL_NOISE, 31'h7FFFFFFF);
        reg_write(REG_MEAS_NOISE, 31'h7FFFFFFF);
        reg_write(REG_DET_THR, 31'($urandom_range(65536)));
        random_phase(200);
        drain();

        reg_write(REG_POS_NOISE, 31'($urandom));
        reg_write(REG_VEL_NOISE, 31'($urandom_range(100000)));
        reg_write(REG_MEAS_NOISE, 31'($urandom_range(300000)));
        reg_write(REG_DET_THR, 31'($urandom_range(1000)));
        random_phase(500);
        drain();

        stim_done = 1'b1;
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
